// File: rtl/svc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_pkg
// Shared types and constants for the version string classifier.
// ----------------------------------------------------------------------------
package svc_pkg;

  // Longest string whose position is tracked; positions saturate at it.
  localparam int MAX_LEN = 255;
  localparam logic [7:0] POS_LIMIT = (MAX_LEN < 255) ? 8'(MAX_LEN) : 8'd255;

  // Queue between character decode and the parser.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Delimiter and digit characters.
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  // Result verdict codes.
  localparam logic [1:0] VERDICT_NOT_VERSION = 2'd0;
  localparam logic [1:0] VERDICT_UNKNOWN     = 2'd1;
  localparam logic [1:0] VERDICT_SEMVER      = 2'd2;

  // One decoded character as it travels through the queue.
  typedef struct packed {
    logic is_end;
    logic dig;
    logic zero;
    logic alpha;
    logic hyphen;
    logic dot;
    logic plus;
    logic ident;
  } ch_class_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/svc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_front
// Input side: takes characters and pushes their decoded class to the queue.
// ----------------------------------------------------------------------------
module svc_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_ch,
  input  logic                  in_is_end,
  input  svc_pkg::q_status_t    q_stat,
  output logic                  push,
  output svc_pkg::ch_class_t    push_entry
);
  import svc_pkg::*;

  logic dig, alpha;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign dig   = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign alpha = ((in_ch >= CH_UC_A) && (in_ch <= CH_UC_Z)) ||
                 ((in_ch >= CH_LC_A) && (in_ch <= CH_LC_Z));

  always_comb begin
    push_entry.is_end = in_is_end;
    push_entry.dig    = dig;
    push_entry.zero   = (in_ch == CH_ZERO);
    push_entry.alpha  = alpha;
    push_entry.hyphen = (in_ch == CH_HYPHEN);
    push_entry.dot    = (in_ch == CH_DOT);
    push_entry.plus   = (in_ch == CH_PLUS);
    push_entry.ident  = dig || alpha || (in_ch == CH_HYPHEN);
  end

endmodule

// File: rtl/svc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_fifo
// Short queue of decoded characters between decode and parser.
// ----------------------------------------------------------------------------
module svc_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  svc_pkg::ch_class_t    push_entry,
  input  logic                  pop,
  output svc_pkg::ch_class_t    head,
  output svc_pkg::q_status_t    q_stat
);
  import svc_pkg::*;

  ch_class_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/svc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_back
// Parser: walks the version grammar and registers one result per string.
// ----------------------------------------------------------------------------
module svc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svc_pkg::ch_class_t    head,
  input  svc_pkg::q_status_t    q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_verdict,
  output logic                  out_is_prerelease,
  output logic                  out_has_prerelease_tag,
  output logic                  out_has_meta_tag,
  output logic [7:0]            out_major_count,
  output logic [7:0]            out_minor_count,
  output logic [7:0]            out_patch_count,
  output logic [7:0]            out_minor_start,
  output logic [7:0]            out_patch_start,
  output logic [7:0]            out_pre_fields,
  output logic [7:0]            out_meta_fields
);
  import svc_pkg::*;

  typedef enum logic [3:0] {
    M_START, M_MAJOR, M_MINOR, M_PATCH, M_PRE_FIRST, M_PRE_FIELD,
    M_PRE_ALNUM, M_PRE_NUM, M_META_FIRST, M_META_FIELD
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE, EV_NOTVER, EV_UNKNOWN
  } ev_t;

  function automatic logic [7:0] inc8(input logic [7:0] v);
    return (v != 8'hFF) ? v + 8'd1 : v;
  endfunction

  function automatic logic [7:0] dec8(input logic [7:0] v);
    return (v != 8'd0) ? v - 8'd1 : v;
  endfunction

  mode_t      mode_r, mode_nxt;
  ev_t        ev_r, ev_nxt;
  logic [7:0] major_r, major_nxt, minor_r, minor_nxt, patch_r, patch_nxt;
  logic [2:0] zl_r, zl_nxt;
  logic       pre_flag_r, pre_flag_nxt;
  logic [1:0] tag_r, tag_nxt;
  logic [7:0] pre_cnt_r, pre_cnt_nxt, meta_cnt_r, meta_cnt_nxt;
  logic       fzl_r, fzl_nxt, na_r, na_nxt;
  logic [7:0] pos_r, pos_nxt, minor_pos_r, minor_pos_nxt, patch_pos_r, patch_pos_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [1:0] res_verdict;
  logic       res_is_pre, res_has_pre, res_has_meta;
  logic [7:0] res_pre_fields;
  logic       emit;

  // Characters drain freely; a terminator waits for the output register.
  assign pop  = !q_stat.empty && (!head.is_end || !out_valid_r || out_ready);
  assign emit = pop && head.is_end;
  assign out_valid = out_valid_r;

  // Verdict for the string closed by the terminator at the head.
  always_comb begin
    res_is_pre     = pre_flag_r;
    res_has_pre    = 1'b0;
    res_has_meta   = 1'b0;
    res_pre_fields = pre_cnt_r;
    if (ev_r == EV_NOTVER || (ev_r == EV_NONE && mode_r == M_START)) begin
      res_verdict = VERDICT_NOT_VERSION;
    end else if (ev_r == EV_UNKNOWN) begin
      res_verdict = VERDICT_UNKNOWN;
    end else if (na_r) begin
      res_pre_fields = dec8(pre_cnt_r);
      res_verdict    = VERDICT_UNKNOWN;
    end else begin
      res_has_pre  = tag_r[0];
      res_has_meta = tag_r[1];
      res_is_pre   = pre_flag_r | tag_r[0];
      if ((mode_r == M_PATCH && patch_r != 8'd0) || mode_r == M_PRE_ALNUM ||
          mode_r == M_PRE_NUM || mode_r == M_META_FIELD) begin
        res_verdict = VERDICT_SEMVER;
      end else begin
        res_verdict = VERDICT_UNKNOWN;
      end
    end
  end

  // Grammar step for one character.
  always_comb begin
    mode_nxt      = mode_r;
    ev_nxt        = ev_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    patch_nxt     = patch_r;
    zl_nxt        = zl_r;
    pre_flag_nxt  = pre_flag_r;
    tag_nxt       = tag_r;
    pre_cnt_nxt   = pre_cnt_r;
    meta_cnt_nxt  = meta_cnt_r;
    fzl_nxt       = fzl_r;
    na_nxt        = na_r;
    pos_nxt       = pos_r;
    minor_pos_nxt = minor_pos_r;
    patch_pos_nxt = patch_pos_r;

    if (emit) begin
      // Clear everything for the next string.
      mode_nxt      = M_START;
      ev_nxt        = EV_NONE;
      major_nxt     = '0;
      minor_nxt     = '0;
      patch_nxt     = '0;
      zl_nxt        = '0;
      pre_flag_nxt  = 1'b0;
      tag_nxt       = '0;
      pre_cnt_nxt   = '0;
      meta_cnt_nxt  = '0;
      fzl_nxt       = 1'b0;
      na_nxt        = 1'b0;
      pos_nxt       = '0;
      minor_pos_nxt = '0;
      patch_pos_nxt = '0;
    end else if (pop) begin
      if (pos_r < POS_LIMIT) begin
        pos_nxt = pos_r + 8'd1;
      end
      if (ev_r == EV_NONE) begin
        unique case (mode_r)
          M_START: begin
            if (!head.dig) begin
              ev_nxt = EV_NOTVER;
            end else begin
              mode_nxt  = M_MAJOR;
              major_nxt = inc8(major_r);
              if (head.zero) zl_nxt[0] = 1'b1;
            end
          end
          M_MAJOR: begin
            if (head.dot) begin
              if (zl_r[0]) pre_flag_nxt = 1'b1;
              minor_pos_nxt = inc8(pos_r);
              mode_nxt      = M_MINOR;
            end else if (!head.dig || zl_r[0]) begin
              ev_nxt = EV_UNKNOWN;
            end else begin
              major_nxt = inc8(major_r);
            end
          end
          M_MINOR: begin
            if (head.dot) begin
              if (minor_r == 8'd0) begin
                ev_nxt = EV_UNKNOWN;
              end else begin
                patch_pos_nxt = inc8(pos_r);
                mode_nxt      = M_PATCH;
              end
            end else if (!head.dig || zl_r[1]) begin
              ev_nxt = EV_UNKNOWN;
            end else begin
              if (head.zero && minor_r == 8'd0) zl_nxt[1] = 1'b1;
              minor_nxt = inc8(minor_r);
            end
          end
          M_PATCH: begin
            if (patch_r != 8'd0 && head.hyphen) begin
              tag_nxt[0] = 1'b1;
              mode_nxt   = M_PRE_FIRST;
            end else if (patch_r != 8'd0 && head.plus) begin
              tag_nxt[1] = 1'b1;
              mode_nxt   = M_META_FIRST;
            end else if (!head.dig || zl_r[2]) begin
              ev_nxt = EV_UNKNOWN;
            end else begin
              if (head.zero && patch_r == 8'd0) zl_nxt[2] = 1'b1;
              patch_nxt = inc8(patch_r);
            end
          end
          M_PRE_FIRST, M_PRE_FIELD: begin
            if (!head.ident) begin
              ev_nxt = EV_UNKNOWN;
            end else begin
              mode_nxt    = head.dig ? M_PRE_NUM : M_PRE_ALNUM;
              fzl_nxt     = head.zero;
              na_nxt      = 1'b0;
              pre_cnt_nxt = inc8(pre_cnt_r);
            end
          end
          M_PRE_ALNUM: begin
            if (head.dot) begin
              mode_nxt = M_PRE_FIELD;
            end else if (head.plus) begin
              tag_nxt[1] = 1'b1;
              mode_nxt   = M_META_FIRST;
            end else if (!head.ident) begin
              ev_nxt = EV_UNKNOWN;
            end
          end
          M_PRE_NUM: begin
            if (head.dig) begin
              if (fzl_r) na_nxt = 1'b1;
            end else if (na_r && (head.dot || head.plus)) begin
              // Numeric field with a leading zero never got its letter.
              pre_cnt_nxt = dec8(pre_cnt_r);
              ev_nxt      = EV_UNKNOWN;
            end else if (head.dot) begin
              mode_nxt = M_PRE_FIELD;
            end else if (head.plus) begin
              tag_nxt[1] = 1'b1;
              mode_nxt   = M_META_FIRST;
            end else if (head.alpha || head.hyphen) begin
              mode_nxt = M_PRE_ALNUM;
              fzl_nxt  = 1'b0;
              na_nxt   = 1'b0;
            end else begin
              ev_nxt = EV_UNKNOWN;
            end
          end
          M_META_FIRST: begin
            if (!head.ident) begin
              ev_nxt = EV_UNKNOWN;
            end else begin
              mode_nxt     = M_META_FIELD;
              meta_cnt_nxt = inc8(meta_cnt_r);
            end
          end
          M_META_FIELD: begin
            if (head.dot) begin
              mode_nxt = M_META_FIRST;
            end else if (!head.ident) begin
              ev_nxt = EV_UNKNOWN;
            end
          end
          default: begin
            ev_nxt = EV_UNKNOWN;
          end
        endcase
      end
    end
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_START;
      ev_r        <= EV_NONE;
      major_r     <= '0;
      minor_r     <= '0;
      patch_r     <= '0;
      zl_r        <= '0;
      pre_flag_r  <= 1'b0;
      tag_r       <= '0;
      pre_cnt_r   <= '0;
      meta_cnt_r  <= '0;
      fzl_r       <= 1'b0;
      na_r        <= 1'b0;
      pos_r       <= '0;
      minor_pos_r <= '0;
      patch_pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      ev_r        <= ev_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      patch_r     <= patch_nxt;
      zl_r        <= zl_nxt;
      pre_flag_r  <= pre_flag_nxt;
      tag_r       <= tag_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      meta_cnt_r  <= meta_cnt_nxt;
      fzl_r       <= fzl_nxt;
      na_r        <= na_nxt;
      pos_r       <= pos_nxt;
      minor_pos_r <= minor_pos_nxt;
      patch_pos_r <= patch_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_verdict            <= res_verdict;
      out_is_prerelease      <= res_is_pre;
      out_has_prerelease_tag <= res_has_pre;
      out_has_meta_tag       <= res_has_meta;
      out_major_count        <= major_r;
      out_minor_count        <= minor_r;
      out_patch_count        <= patch_r;
      out_minor_start        <= minor_pos_r;
      out_patch_start        <= patch_pos_r;
      out_pre_fields         <= res_pre_fields;
      out_meta_fields        <= meta_cnt_r;
    end
  end

endmodule

// File: rtl/semver_string_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semver_string_classifier
// Classifies a character stream as not-a-version, unknown or SemVer 2.0.0.
// ----------------------------------------------------------------------------
//
//   channel   ports                       moves per transfer
//   -------   -------------------------   ---------------------------------
//   in        in_valid / in_ready         one character or a terminator
//   out       out_valid / out_ready       one verdict per terminator
//
// Each character transfers while in_ready is high; the parser retires one
// queued character per cycle unless a terminator waits on a stalled result,
// so the sustained rate is one item per clock while results are taken.
// out_valid rises at the edge that pops the terminator from the queue.
// Reset (rst_n low, synchronous) empties the queue, clears the parser and
// drops out_valid. in_ready falls only when the four-entry queue is full,
// which happens when a terminator waits behind a stalled result.
//
module semver_string_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_is_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict,
  output logic       out_is_prerelease,
  output logic       out_has_prerelease_tag,
  output logic       out_has_meta_tag,
  output logic [7:0] out_major_count,
  output logic [7:0] out_minor_count,
  output logic [7:0] out_patch_count,
  output logic [7:0] out_minor_start,
  output logic [7:0] out_patch_start,
  output logic [7:0] out_pre_fields,
  output logic [7:0] out_meta_fields
);
  import svc_pkg::*;

  ch_class_t push_entry, head;
  q_status_t q_stat;
  logic      push, pop;

  // Decode each character into its class and push it.
  svc_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch      (in_ch),
    .in_is_end  (in_is_end),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Hold decoded characters while the result side stalls.
  svc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Walk the grammar and register the verdict.
  svc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head                   (head),
    .q_stat                 (q_stat),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_verdict            (out_verdict),
    .out_is_prerelease      (out_is_prerelease),
    .out_has_prerelease_tag (out_has_prerelease_tag),
    .out_has_meta_tag       (out_has_meta_tag),
    .out_major_count        (out_major_count),
    .out_minor_count        (out_minor_count),
    .out_patch_count        (out_patch_count),
    .out_minor_start        (out_minor_start),
    .out_patch_start        (out_patch_start),
    .out_pre_fields         (out_pre_fields),
    .out_meta_fields        (out_meta_fields)
  );

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A new result only follows a terminator leaving the queue.
  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop && head.is_end))
    else $error("result without terminator");

  // A verdict is one of the three defined codes.
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_NOT_VERSION ||
                   out_verdict == VERDICT_UNKNOWN ||
                   out_verdict == VERDICT_SEMVER))
    else $error("bad verdict code");

  // A reported prerelease tag always marks the version as prerelease.
  a_tag_marks_pre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_prerelease_tag |-> out_is_prerelease)
    else $error("prerelease tag without prerelease flag");

endmodule
